// File: src/sha1md_pkg.sv
`timescale 1ns / 1ps
package sha1md_pkg;

	typedef logic [31:0] word_t;

	localparam int DIGEST_WORDS = 5;
	localparam int ROUNDS       = 80;
	localparam int WIN_WORDS    = 16;

	localparam logic [6:0] BLOCK_BYTES = 7'd64;
	localparam logic [5:0] LEN_POS     = 6'd56;
	localparam logic [7:0] PAD_BYTE    = 8'h80;
	localparam logic [2:0] WORD_BYTES  = 3'd4;
	localparam logic [2:0] LAST_INDEX  = 3'd4;

	localparam word_t IV [DIGEST_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	// byte insertion into the schedule window, plus the length write
	typedef struct packed {
		logic        en;
		logic [5:0]  pos;
		logic [2:0]  cnt;
		word_t       data;
		logic        len_en;
		logic [63:0] len;
	} wr_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

endpackage

// File: src/sha1md_if.sv
`timescale 1ns / 1ps
interface sha1md_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] message_word;
	logic [2:0]  valid_bytes;
	logic        last;

	modport source (output valid, output message_word, output valid_bytes, output last,
		input ready);
	modport sink (input valid, input message_word, input valid_bytes, input last,
		output ready);
endinterface

interface sha1md_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        digest_last;

	modport source (output valid, output digest_word, output word_index, output digest_last,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input digest_last,
		output ready);
endinterface

// File: src/sha1_message_digest.sv
`timescale 1ns / 1ps
// SHA-1 digest of a byte stream.
// msg (sink): big-endian 32-bit words; valid_bytes counts bytes from the high end
// (5..7 count as 4), last marks the final word. A beat moves when valid and ready are high.
// dig (source): five digest beats per message, word_index 0..4, digest_last on the fifth.
// A word that does not complete a 64-byte block leaves ready high unless it is the last
// word. A word that completes one holds ready low while one shared round unit runs 80
// rounds at one per cycle and a final step adds into the chaining words; a load of the
// leftover bytes of that word follows when any are left over.
// After the last word the sequencer writes 0x80, zero-fills up to four bytes a
// cycle to byte 56, writes the 64-bit length and compresses; a second block is used
// when the padding does not fit.
// Digest beats come from a single output register; when the receiver stalls the
// sequencer holds, and msg stays low until the fifth beat is loaded into it.
// Reset loads the SHA-1 initial chaining words, clears the length and position and
// leaves the block idle and ready for the first word of a message.
module sha1_message_digest import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sha1md_msg_if.sink  msg,
	sha1md_dig_if.source dig
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOAD  = 7'b0000010,
		S_COMP  = 7'b0000100,
		S_PAD80 = 7'b0001000,
		S_ZERO  = 7'b0010000,
		S_LEN   = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t      state_q, ret_q, after_ins;
	logic [5:0]  pos_q, pos_next;
	word_t       hold_data_q;
	logic [2:0]  hold_cnt_q;
	logic        hold_last_q;
	logic [63:0] len_q;
	logic [2:0]  emit_q;
	logic        out_valid_q, out_last_q;
	word_t       out_word_q, h_sel;
	logic [2:0]  out_idx_q;

	logic [2:0]  in_cnt, src_cnt, n, zero_n, rest;
	word_t       src_data;
	logic        src_last, accept, do_ins, fill, load_out, iv_load, start;
	logic [6:0]  room, zero_lim;
	wr_req_t     wr;
	core_sts_t   sts;
	word_t       h [DIGEST_WORDS];

	sha1md_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.start   (start),
		.iv_load (iv_load),
		.sts     (sts),
		.h       (h)
	);

	assign msg.ready = (state_q == S_IDLE);
	assign accept    = msg.valid && msg.ready;
	assign in_cnt    = (msg.valid_bytes > WORD_BYTES) ? WORD_BYTES : msg.valid_bytes;
	assign room      = BLOCK_BYTES - {1'b0, pos_q};
	assign zero_lim  = (pos_q < LEN_POS) ? {1'b0, LEN_POS - pos_q} : room;
	assign zero_n    = (zero_lim > {4'b0000, WORD_BYTES}) ? WORD_BYTES : zero_lim[2:0];

	always_comb begin
		src_data = '0;
		src_cnt  = '0;
		src_last = 1'b0;
		case (state_q)
			S_IDLE: begin
				src_data = msg.message_word;
				src_cnt  = in_cnt;
				src_last = msg.last;
			end
			S_LOAD: begin
				src_data = hold_data_q;
				src_cnt  = hold_cnt_q;
				src_last = hold_last_q;
			end
			S_PAD80: begin
				src_data = {PAD_BYTE, 24'h000000};
				src_cnt  = 3'd1;
			end
			S_ZERO: begin
				src_cnt = zero_n;
			end
			default: begin
				src_cnt = '0;
			end
		endcase
	end

	assign n        = ({4'b0000, src_cnt} > room) ? room[2:0] : src_cnt;
	assign fill     = (n != 3'd0) && ({4'b0000, n} == room);
	assign pos_next = pos_q + {3'b000, n};
	assign rest     = src_cnt - n;
	assign do_ins   = accept || (state_q == S_LOAD) || (state_q == S_PAD80) ||
		(state_q == S_ZERO && pos_q != LEN_POS);
	assign start    = (do_ins && fill) || (state_q == S_LEN);

	always_comb begin
		if (rest != 3'd0) begin
			after_ins = S_LOAD;
		end else if (src_last) begin
			after_ins = S_PAD80;
		end else begin
			after_ins = S_IDLE;
		end
	end

	always_comb begin
		wr.en     = do_ins;
		wr.pos    = pos_q;
		wr.cnt    = n;
		wr.data   = src_data;
		wr.len_en = (state_q == S_LEN);
		wr.len    = len_q;
	end

	always_comb begin
		case (emit_q)
			3'd0:    h_sel = h[0];
			3'd1:    h_sel = h[1];
			3'd2:    h_sel = h[2];
			3'd3:    h_sel = h[3];
			3'd4:    h_sel = h[4];
			default: h_sel = '0;
		endcase
	end

	assign load_out = (state_q == S_EMIT) && (!out_valid_q || dig.ready);
	assign iv_load  = load_out && (emit_q == LAST_INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			pos_q       <= '0;
			hold_cnt_q  <= '0;
			hold_last_q <= 1'b0;
			len_q       <= '0;
			emit_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE, S_LOAD: begin
					if (do_ins) begin
						pos_q       <= pos_next;
						hold_cnt_q  <= rest;
						hold_last_q <= src_last;
						if (state_q == S_IDLE) begin
							len_q <= len_q + {58'd0, in_cnt, 3'b000};
						end
						if (fill) begin
							state_q <= S_COMP;
							ret_q   <= after_ins;
						end else begin
							state_q <= after_ins;
						end
					end
				end
				S_PAD80: begin
					pos_q <= pos_next;
					if (fill) begin
						state_q <= S_COMP;
						ret_q   <= S_ZERO;
					end else begin
						state_q <= S_ZERO;
					end
				end
				S_ZERO: begin
					if (pos_q == LEN_POS) begin
						state_q <= S_LEN;
					end else begin
						pos_q <= pos_next;
						if (fill) begin
							state_q <= S_COMP;
							ret_q   <= S_ZERO;
						end
					end
				end
				S_LEN: begin
					pos_q   <= '0;
					len_q   <= '0;
					state_q <= S_COMP;
					ret_q   <= S_EMIT;
				end
				S_COMP: begin
					if (sts.done) begin
						state_q <= ret_q;
					end
				end
				S_EMIT: begin
					if (load_out) begin
						if (emit_q == LAST_INDEX) begin
							emit_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							emit_q <= emit_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// leftover bytes of a word that completed a block, high byte first
	always_ff @(posedge clk) begin
		if (do_ins && (state_q == S_IDLE)) begin
			hold_data_q <= src_data << {n, 3'b000};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (dig.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q <= h_sel;
			out_idx_q  <= emit_q;
			out_last_q <= (emit_q == LAST_INDEX);
		end
	end

	assign dig.valid       = out_valid_q;
	assign dig.digest_word = out_word_q;
	assign dig.word_index  = out_idx_q;
	assign dig.digest_last = out_last_q;

`ifndef SYNTHESIS
	a_done_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == S_COMP)
		else $error("compression finished outside the wait state");

	a_len_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LEN |-> pos_q == LEN_POS)
		else $error("length written at a wrong byte position");

	a_no_ins_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !do_ins && !msg.ready)
		else $error("window written while rounds run");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> (dig.digest_last == (dig.word_index == LAST_INDEX)))
		else $error("digest_last out of step with word_index");
`endif

endmodule

// File: src/sha1md_core.sv
`timescale 1ns / 1ps
module sha1md_core import sha1md_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  wr_req_t   wr,
	input  logic      start,
	input  logic      iv_load,
	output core_sts_t sts,
	output word_t     h [DIGEST_WORDS]
);

	typedef enum logic [2:0] {
		C_IDLE  = 3'b001,
		C_ROUND = 3'b010,
		C_FINAL = 3'b100
	} cstate_t;

	cstate_t     state_q;
	logic [6:0]  round_q;
	word_t       h_q [DIGEST_WORDS];
	word_t       a_q, b_q, c_q, d_q, e_q;
	word_t       win_q [WIN_WORDS];
	word_t       win_d [WIN_WORDS];
	word_t       f, k, tmp, w_new;

	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + win_q[0];
	end

	// window holds W[t..t+15]; next entry is W[t+16]
	always_comb begin
		w_new = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		w_new = {w_new[30:0], w_new[31]};
	end

	always_comb begin
		logic [5:0]  off;
		logic [31:0] sh;
		off = '0;
		sh  = '0;
		for (int j = 0; j < WIN_WORDS; j++) begin
			win_d[j] = win_q[j];
		end
		if (state_q == C_ROUND) begin
			for (int j = 0; j < WIN_WORDS - 1; j++) begin
				win_d[j] = win_q[j + 1];
			end
			win_d[WIN_WORDS - 1] = w_new;
		end else begin
			for (int j = 0; j < WIN_WORDS; j++) begin
				for (int l = 0; l < 4; l++) begin
					off = 6'(4 * j + l) - wr.pos;
					sh  = wr.data << {off[1:0], 3'b000};
					if (wr.en && (off < {3'b000, wr.cnt})) begin
						win_d[j][31 - 8 * l -: 8] = sh[31:24];
					end
				end
			end
			if (wr.len_en) begin
				win_d[WIN_WORDS - 2] = wr.len[63:32];
				win_d[WIN_WORDS - 1] = wr.len[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	always_ff @(posedge clk) begin
		if (start && state_q == C_IDLE) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == C_ROUND) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
			h_q     <= IV;
		end else begin
			case (state_q)
				C_IDLE: begin
					round_q <= '0;
					if (iv_load) begin
						h_q <= IV;
					end
					if (start) begin
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == 7'(ROUNDS - 1)) begin
						state_q <= C_FINAL;
					end
				end
				C_FINAL: begin
					h_q[0]  <= h_q[0] + a_q;
					h_q[1]  <= h_q[1] + b_q;
					h_q[2]  <= h_q[2] + c_q;
					h_q[3]  <= h_q[3] + d_q;
					h_q[4]  <= h_q[4] + e_q;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign sts.busy = (state_q != C_IDLE);
	assign sts.done = (state_q == C_FINAL);
	assign h        = h_q;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import sha1md_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 10;
	localparam int TARGET_ITEMS = 120;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 250;
	localparam int REPORT_MAX   = 10;

	typedef enum logic [1:0] {STALL_NONE, STALL_CHOPPY, STALL_LONG} stall_mode_t;

	typedef struct {
		word_t      data;
		logic [2:0] nbytes;
		logic       last;
	} msg_beat_t;

	typedef struct {
		word_t      data;
		logic [2:0] index;
		logic       last;
	} digest_beat_t;

	logic clk;
	logic arst_n;

	sha1md_msg_if msg_ch ();
	sha1md_dig_if dig_ch ();

	sha1_message_digest i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.dig    (dig_ch)
	);

	// predictor state
	word_t       hash_state [DIGEST_WORDS];
	word_t       sched_win [WIN_WORDS];
	logic [63:0] msg_bits;
	int          blk_pos;

	msg_beat_t    msg_backlog [$];
	digest_beat_t digest_due [$];

	int          item_count;
	int          fail_count;
	int          idle_cycles;
	int          burst_left;
	int          gap_left;
	int          stall_left;
	int          cycle_count;
	stall_mode_t stall_mode;
	logic        msg_taken;
	logic        dig_taken;
	msg_beat_t   next_beat;
	digest_beat_t want;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic word_t rotl(word_t x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic sha1_compress();
		word_t a, b, c, d, e, f, k, w, sum;
		int r;
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (r = 0; r < ROUNDS; r++) begin
			if (r < WIN_WORDS) begin
				w = sched_win[r];
			end else begin
				w = rotl(sched_win[(r - 3) % 16] ^ sched_win[(r - 8) % 16] ^
					sched_win[(r - 14) % 16] ^ sched_win[r % 16], 1);
				sched_win[r % 16] = w;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			sum = rotl(a, 5) + f + e + k + w;
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = sum;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endtask

	task automatic push_byte(logic [7:0] value);
		int idx, sh;
		idx = blk_pos / 4;
		sh = (3 - blk_pos % 4) * 8;
		sched_win[idx] = (sched_win[idx] & ~(32'hFF << sh)) | (word_t'(value) << sh);
		blk_pos++;
		if (blk_pos == BLOCK_BYTES) begin
			sha1_compress();
			blk_pos = 0;
		end
	endtask

	// fold one accepted beat into the hash; a last beat pads and queues the digest
	task automatic absorb_beat(msg_beat_t mb);
		int n, i;
		logic [63:0] len;
		digest_beat_t db;
		n = (mb.nbytes > WORD_BYTES) ? WORD_BYTES : mb.nbytes;
		for (i = 0; i < n; i++) begin
			push_byte(mb.data[31 - 8 * i -: 8]);
			msg_bits += 64'd8;
		end
		if (mb.last) begin
			len = msg_bits;
			push_byte(PAD_BYTE);
			while (blk_pos != LEN_POS)
				push_byte(8'h00);
			for (i = 0; i < 8; i++)
				push_byte(len[63 - 8 * i -: 8]);
			for (i = 0; i < DIGEST_WORDS; i++) begin
				db.data = hash_state[i];
				db.index = 3'(i);
				db.last = (i == LAST_INDEX);
				digest_due = {digest_due, db};
			end
			hash_state = IV;
			msg_bits = '0;
			blk_pos = 0;
		end
	endtask

	task automatic add_beat(word_t data, logic [2:0] nbytes, logic last);
		msg_beat_t mb;
		mb.data = data;
		mb.nbytes = nbytes;
		mb.last = last;
		msg_backlog = {msg_backlog, mb};
		if (nbytes != 0 || last)
			item_count++;
	endtask

	// mostly full words; now and then a short, empty or oversized one mid-message
	task automatic add_message(int nwords);
		int i;
		logic [2:0] nb;
		for (i = 0; i < nwords - 1; i++) begin
			nb = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : WORD_BYTES;
			add_beat($urandom, nb, 1'b0);
		end
		add_beat($urandom, 3'($urandom_range(0, 7)), 1'b1);
	endtask

	// sender: bursts of beats separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			msg_ch.valid <= 1'b0;
		end else if (msg_taken || !msg_ch.valid) begin
			if (gap_left > 0) begin
				gap_left--;
				msg_ch.valid <= 1'b0;
			end else if (msg_backlog.size() > 0) begin
				next_beat = msg_backlog.pop_front();
				msg_ch.message_word <= next_beat.data;
				msg_ch.valid_bytes <= next_beat.nbytes;
				msg_ch.last <= next_beat.last;
				msg_ch.valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end
			end else begin
				msg_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern drawn at random from none, choppy and long stalls
	always @(negedge clk) begin
		cycle_count++;
		if (cycle_count % 256 == 0)
			stall_mode = stall_mode_t'($urandom_range(0, 2));
		case (stall_mode)
			STALL_NONE: begin
				dig_ch.ready <= 1'b1;
			end
			STALL_CHOPPY: begin
				dig_ch.ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					dig_ch.ready <= 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(4, 30);
					dig_ch.ready <= 1'b0;
				end else begin
					dig_ch.ready <= 1'b1;
				end
			end
		endcase
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		msg_taken = arst_n && msg_ch.valid && msg_ch.ready;
		dig_taken = arst_n && dig_ch.valid && dig_ch.ready;
		if (msg_taken) begin
			next_beat.data = msg_ch.message_word;
			next_beat.nbytes = msg_ch.valid_bytes;
			next_beat.last = msg_ch.last;
			absorb_beat(next_beat);
		end
		if (dig_taken) begin
			if (digest_due.size() == 0) begin
				if (fail_count < REPORT_MAX)
					$display("unexpected digest beat: word %h index %0d last %b",
						dig_ch.digest_word, dig_ch.word_index, dig_ch.digest_last);
				fail_count++;
			end else begin
				want = digest_due.pop_front();
				if (dig_ch.digest_word !== want.data || dig_ch.word_index !== want.index ||
						dig_ch.digest_last !== want.last) begin
					if (fail_count < REPORT_MAX)
						$display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
							want.data, want.index, want.last,
							dig_ch.digest_word, dig_ch.word_index, dig_ch.digest_last);
					fail_count++;
				end
			end
		end
		if (msg_taken || dig_taken)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.message_word = '0;
		msg_ch.valid_bytes = '0;
		msg_ch.last = 1'b0;
		dig_ch.ready = 1'b0;
		msg_taken = 1'b0;
		dig_taken = 1'b0;
		item_count = 0;
		fail_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		stall_left = 0;
		cycle_count = 0;
		stall_mode = STALL_NONE;
		hash_state = IV;
		foreach (sched_win[i])
			sched_win[i] = '0;
		msg_bits = '0;
		blk_pos = 0;

		// empty message
		add_beat(32'hFFFF_FFFF, 3'd0, 1'b1);
		// "abc"
		add_beat(32'h6162_6300, 3'd3, 1'b1);
		add_beat(32'hFFFF_FFFF, 3'd4, 1'b1);
		// oversized count on the last word
		add_beat(32'h0000_0000, 3'd7, 1'b1);
		// short, empty and oversized words mid-message, then an empty last word
		add_beat($urandom, 3'd1, 1'b0);
		add_beat($urandom, 3'd0, 1'b0);
		add_beat($urandom, 3'd5, 1'b0);
		add_beat($urandom, 3'd0, 1'b1);
		add_beat($urandom, 3'd6, 1'b0);
		add_beat($urandom, 3'd2, 1'b1);
		// 56 bytes: padding spills into a second block
		repeat (13)
			add_beat($urandom, WORD_BYTES, 1'b0);
		add_beat($urandom, WORD_BYTES, 1'b1);

		while (item_count < TARGET_ITEMS)
			add_message(($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) :
				$urandom_range(1, 16));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (msg_backlog.size() != 0 || msg_ch.valid)
			@(posedge clk);
		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
